FILE: hdl/stereo_resampler_ring_fifo_top_defines.svh
// Assertion helpers for the RTL datapath.
`ifndef STEREO_RESAMPLER_RING_FIFO_TOP_DEFINES_SVH
`define STEREO_RESAMPLER_RING_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/srrf_pkg.sv
`timescale 1ns / 1ps

package srrf_pkg;

  localparam int RING_DEPTH  = 16384;
  localparam int FRAME_DEPTH = 1024;
  localparam int BLOCK_WORDS = 800;

  localparam int RING_AW  = $clog2(RING_DEPTH);
  localparam int FRAME_AW = $clog2(FRAME_DEPTH);
  localparam int CNT_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

  localparam int SAMPLE_W   = 32;
  localparam int PHASE_W    = 32;
  localparam int PHASE_FRAC = 16;
  localparam int HALF_W     = SAMPLE_W / 2;

  localparam logic [PHASE_W-1:0] STEP_FAST = PHASE_W'(30065);
  localparam logic [PHASE_W-1:0] STEP_SLOW = PHASE_W'(60211);
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(BLOCK_WORDS - 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [RING_AW-1:0]  ring_addr_t;
  typedef logic [FRAME_AW-1:0] frame_addr_t;
  typedef logic [PHASE_W-1:0]  phase_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_PULL = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PULL_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic frame_wr;
    logic frame_last;
    logic rs_start;
    logic rs_read;
    logic pull_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rs_last;
    logic out_free;
  } status_t;

  function automatic sample_t swap_halves(input sample_t w);
    return {w[HALF_W-1:0], w[SAMPLE_W-1:HALF_W]};
  endfunction

endpackage

FILE: hdl/srrf_ifs.sv
`timescale 1ns / 1ps

interface srrf_in_if;
  logic              valid;
  logic              ready;
  srrf_pkg::func_t   func;
  srrf_pkg::sample_t src_sample;
  logic              frame_last;

  modport source (output valid, func, src_sample, frame_last, input ready);
  modport sink   (input valid, func, src_sample, frame_last, output ready);
endinterface

interface srrf_out_if;
  logic              valid;
  logic              ready;
  srrf_pkg::sample_t out_sample;
  logic              out_valid;

  modport source (output valid, out_sample, out_valid, input ready);
  modport sink   (input valid, out_sample, out_valid, output ready);
endinterface

interface srrf_cfg_if;
  logic valid;
  logic ready;
  logic fast_source_mode;

  modport source (output valid, fast_source_mode, input ready);
  modport sink   (input valid, fast_source_mode, output ready);
endinterface

FILE: hdl/srrf_ctrl.sv
`timescale 1ns / 1ps

module srrf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  srrf_pkg::func_t   in_func,
  input  logic              in_last,
  output logic              in_ready,
  input  srrf_pkg::status_t status,
  output srrf_pkg::cmd_t    cmd
);
  import srrf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_PULL) begin
            cmd.pull_rd = 1'b1;
            state_nxt   = ST_PULL_OUT;
          end else begin
            cmd.frame_wr   = 1'b1;
            cmd.frame_last = in_last;
            if (in_last) begin
              cmd.rs_start = 1'b1;
              state_nxt    = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.rs_read = 1'b1;
        if (status.rs_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      ST_PULL_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/srrf_datapath.sv
`timescale 1ns / 1ps
`include "stereo_resampler_ring_fifo_top_defines.svh"

module srrf_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  srrf_pkg::cmd_t    cmd,
  output srrf_pkg::status_t status,
  input  srrf_pkg::sample_t in_sample,
  input  logic              cfg_we,
  input  logic              cfg_fast,
  output logic              out_req_valid,
  input  logic              out_req_ready,
  output srrf_pkg::sample_t out_sample,
  output logic              out_flag
);
  import srrf_pkg::*;

  sample_t frame_mem [FRAME_DEPTH];
  sample_t ring_mem  [RING_DEPTH];

  logic                fast_r;
  frame_addr_t         load_idx_r, load_idx_nxt;
  logic [FRAME_AW:0]   fill_r, fill_nxt;
  phase_t              phase_r, phase_nxt;
  cnt_t                cnt_r, cnt_nxt;
  ring_addr_t          head_r, tail_r;
  logic                wr_pend_r;
  sample_t             frame_rd_r;
  logic                frame_zero_r;
  sample_t             ring_rd_r;
  logic                pull_hit_r;
  logic                out_valid_r;
  sample_t             out_sample_r;
  logic                out_flag_r;

  frame_addr_t rd_idx;
  phase_t      step;
  logic        ring_empty;
  sample_t     ring_wdata;

  assign rd_idx     = phase_r[PHASE_FRAC +: FRAME_AW];
  assign step       = fast_r ? STEP_FAST : STEP_SLOW;
  assign ring_empty = (head_r == tail_r);
  assign ring_wdata = frame_zero_r ? '0 : swap_halves(frame_rd_r);

  always_comb begin
    load_idx_nxt = load_idx_r;
    fill_nxt     = fill_r;
    if (cmd.frame_wr) begin
      load_idx_nxt = cmd.frame_last ? '0 : load_idx_r + 1'b1;
      if ({1'b0, load_idx_r} >= fill_r) begin
        fill_nxt = {1'b0, load_idx_r} + 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    priority if (cmd.rs_start) begin
      phase_nxt = '0;
      cnt_nxt   = '0;
    end else if (cmd.rs_read) begin
      phase_nxt = phase_r + step;
      cnt_nxt   = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r      <= 1'b0;
      load_idx_r  <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fast_r <= cfg_fast;
      end
      load_idx_r <= load_idx_nxt;
      fill_r     <= fill_nxt;
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      wr_pend_r  <= cmd.rs_read;
      if (wr_pend_r) begin
        head_r <= head_r + 1'b1;
      end
      if (cmd.pull_rd && !ring_empty) begin
        tail_r <= tail_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_req_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // frame store: write on push, registered read during resampling
  always_ff @(posedge clk) begin
    if (cmd.frame_wr) begin
      frame_mem[load_idx_r] <= in_sample;
    end
    if (cmd.rs_read) begin
      frame_rd_r   <= frame_mem[rd_idx];
      frame_zero_r <= ({1'b0, rd_idx} >= fill_r);
    end
  end

  // ring store: write one stage behind the frame read, read on pull
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      ring_mem[head_r] <= ring_wdata;
    end
    if (cmd.pull_rd) begin
      ring_rd_r  <= ring_mem[tail_r];
      pull_hit_r <= !ring_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= pull_hit_r ? ring_rd_r : '0;
      out_flag_r   <= pull_hit_r;
    end
  end

  assign status.rs_last  = (cnt_r == CNT_LAST);
  assign status.out_free = !out_valid_r || out_req_ready;
  assign out_req_valid   = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_flag        = out_flag_r;

  `SRRF_ASSERT_NOW(a_no_ring_clash, wr_pend_r, !cmd.pull_rd, "ring write during pull")
  `SRRF_ASSERT_NOW(a_load_free, cmd.out_load, (!out_valid_r || out_req_ready), "out overrun")
  `SRRF_ASSERT_NEXT(a_rs_start, cmd.rs_start, (phase_r == '0 && cnt_r == '0), "bad start")
  `SRRF_ASSERT_NEXT(a_tail_step, (cmd.pull_rd && !ring_empty),
                    (tail_r == $past(tail_r + 1'b1)), "tail not advanced")

endmodule

FILE: hdl/stereo_resampler_ring_fifo_top.sv
`timescale 1ns / 1ps
// Stereo frame buffer with truncating-phase (sample-hold) upsampler and output ring.
// in_if  : requests. func=push stores src_sample in the frame store; a push
//          with frame_last set then writes BLOCK_WORDS (800) channel-swapped
//          words into the ring, stepping a 16.16 phase accumulator.
//          func=pull returns the word at the ring tail, or zero with
//          out_valid low when the ring is empty.
// out_if : one result per pull, held in an output register.
// cfg_if : fast_source_mode, always ready; write only while idle.
// Timing : a push is taken in the idle state. A final push then starts the
//          resampler, one ring write per cycle through the frame store read
//          port, then drains back to idle. A pull does a registered ring
//          read, then loads the output register once it is free; no request
//          is taken until the pull has loaded its result.
// Stall  : a push is still taken while a result waits; a pull waits in the
//          output stage until the held result is taken.
// Reset  : synchronous. Pointers, load index and frame fill count clear;
//          frame entries at and above the fill count read as zero, so no
//          clearing pass is needed. Ring contents are undefined until written.
module stereo_resampler_ring_fifo_top (
  input logic       clk,
  input logic       rst_n,
  srrf_in_if.sink   in_if,
  srrf_out_if.source out_if,
  srrf_cfg_if.sink  cfg_if
);
  import srrf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_if.ready = 1'b1;

  srrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .in_last  (in_if.frame_last),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  srrf_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_sample     (in_if.src_sample),
    .cfg_we        (cfg_if.valid),
    .cfg_fast      (cfg_if.fast_source_mode),
    .out_req_valid (out_if.valid),
    .out_req_ready (out_if.ready),
    .out_sample    (out_if.out_sample),
    .out_flag      (out_if.out_valid)
  );

endmodule
